// ----- src/murmur2_hash32_defines.svh -----
// assertion macros for the hash block
`ifndef MURMUR2_HASH32_DEFINES_SVH
`define MURMUR2_HASH32_DEFINES_SVH

// same-cycle implication
`define M2H_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define M2H_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/m2h_pkg.sv -----
package m2h_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT   = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;

   // controller to datapath commands
   typedef struct packed {
      logic step_a;    // load/mix first half of a beat
      logic use_seed;  // start of message: base is seed ^ length
      logic step_b;    // second half of a full-word mix
      logic fin;       // finalize into the output register
   } dp_cmd_type;

   function automatic logic [31:0] tail_mask(input logic [1:0] nb);
      logic [31:0] m;
      case (nb)
         2'd1:    m = 32'h0000_00ff;
         2'd2:    m = 32'h0000_ffff;
         2'd3:    m = 32'h00ff_ffff;
         default: m = 32'h0000_0000;
      endcase
      return m;
   endfunction

endpackage

// ----- src/m2h_intf.sv -----
interface m2h_req_if;
   logic        valid;
   logic        ready;
   logic        first;
   logic        last;
   logic [31:0] seed;
   logic [31:0] total_length;
   logic [31:0] data_word;
   logic [2:0]  word_bytes;

   modport source (output valid, first, last, seed, total_length, data_word, word_bytes,
                   input ready);
   modport sink   (input valid, first, last, seed, total_length, data_word, word_bytes,
                   output ready);
endinterface

interface m2h_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash;

   modport source (output valid, hash, input ready);
   modport sink   (input valid, hash, output ready);
endinterface

// ----- src/m2h_datapath.sv -----
module m2h_datapath (
   input  logic                clock,
   input  m2h_pkg::dp_cmd_type cmd,
   input  logic [31:0]         seed,
   input  logic [31:0]         total_length,
   input  logic [31:0]         data_word,
   input  logic [2:0]          word_bytes,
   output logic [31:0]         hash
);

   logic [31:0] acc_ff, acc_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] hash_ff, hash_in;

   logic [31:0] base;
   logic [31:0] mul_a_src, mul_a;
   logic [31:0] mul_c_src, mul_c;
   logic        full;
   logic        empty;

   assign full  = word_bytes[2];
   assign empty = (word_bytes == 3'd0);
   assign base  = cmd.use_seed ? (seed ^ total_length) : acc_ff;

   // accumulator multiply, with tail bytes folded in first
   assign mul_a_src = full ? base : (base ^ (data_word & m2h_pkg::tail_mask(word_bytes[1:0])));
   assign mul_a     = mul_a_src * m2h_pkg::MIX_MUL;

   // shared by the second key multiply and finalization
   assign mul_c_src = cmd.fin ? (acc_ff ^ (acc_ff >> m2h_pkg::FIN_SHIFT_A))
                              : (key_ff ^ (key_ff >> m2h_pkg::MIX_SHIFT));
   assign mul_c     = mul_c_src * m2h_pkg::MIX_MUL;

   always_comb begin
      acc_in  = acc_ff;
      key_in  = key_ff;
      hash_in = hash_ff;
      if (cmd.step_a) begin
         acc_in = empty ? base : mul_a;
         key_in = data_word * m2h_pkg::MIX_MUL;
      end
      if (cmd.step_b) begin
         acc_in = acc_ff ^ mul_c;
      end
      if (cmd.fin) begin
         hash_in = mul_c ^ (mul_c >> m2h_pkg::FIN_SHIFT_B);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      key_ff  <= key_in;
      hash_ff <= hash_in;
   end

   assign hash = hash_ff;

endmodule

// ----- src/m2h_ctrl.sv -----
`include "murmur2_hash32_defines.svh"

module m2h_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_first,
   input  logic                req_last,
   input  logic                req_full,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output m2h_pkg::dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MIX,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      open_ff, open_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic take;
   logic slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // words outside a message are dropped
   assign take      = accept && (req_first || open_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cmd.step_a   = take;
   assign cmd.use_seed = req_first;
   assign cmd.step_b   = (state_ff == S_MIX);
   assign cmd.fin      = (state_ff == S_FIN) && slot_free;

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               open_in = 1'b1;
               last_in = req_last;
               if (req_full) begin
                  state_in = S_MIX;
               end else if (req_last) begin
                  state_in = S_FIN;
               end
            end
         end
         S_MIX: begin
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (slot_free) begin
               state_in     = S_IDLE;
               open_in      = 1'b0;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `M2H_ASSERT_NEXT(a_full_word_mixes, take && req_full, state_ff == S_MIX, "full word skipped mix")
   `M2H_ASSERT_NEXT(a_fin_emits, cmd.fin, rsp_valid_ff && !open_ff && state_ff == S_IDLE, "finalize lost")
   `M2H_ASSERT_NEXT(a_stray_ignored, accept && !req_first && !open_ff, state_ff == S_IDLE && !open_ff, "stray beat used")
   `M2H_ASSERT_NOW(a_mix_in_message, state_ff == S_MIX || state_ff == S_FIN, open_ff, "busy outside message")

endmodule

// ----- src/murmur2_hash32.sv -----
// 32-bit MurmurHash2 over a message sent as little-endian 32-bit word beats. A beat with first
// set opens a message (seed ^ total_length); a beat with word_bytes of 4 or more is taken and
// then mixed in the S_MIX state, a beat with 0 to 3 bytes is folded in as it is taken, and a
// beat with last set then passes S_FIN to finalize, after which the hash sits in the output
// register (S_FIN waits while an earlier hash is still unread). S_MIX is there for the chained
// key multiplies; the second key multiply shares one multiplier with finalization. Beats without
// first outside a message are dropped. total_length is not checked against the bytes sent.
module murmur2_hash32 (
   input logic       clock,
   input logic       reset,
   m2h_req_if.sink   req,
   m2h_rsp_if.source rsp
);

   m2h_pkg::dp_cmd_type cmd;
   logic                ready_w;
   logic                valid_w;
   logic [31:0]         hash_w;

   m2h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_first (req.first),
      .req_last  (req.last),
      .req_full  (req.word_bytes[2]),
      .req_ready (ready_w),
      .rsp_ready (rsp.ready),
      .rsp_valid (valid_w),
      .cmd       (cmd)
   );

   m2h_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .seed         (req.seed),
      .total_length (req.total_length),
      .data_word    (req.data_word),
      .word_bytes   (req.word_bytes),
      .hash         (hash_w)
   );

   assign req.ready = ready_w;
   assign rsp.valid = valid_w;
   assign rsp.hash  = hash_w;

endmodule
